// ----- rtl/kbsc_pkg.sv -----
// ----------------------------------------------------------------------------
// kbsc_pkg
// Shared constants, codes and helpers for the keyed byte stream cipher.
// ----------------------------------------------------------------------------
package kbsc_pkg;

  localparam int unsigned HALF_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(HALF_DEPTH);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [KEY_W-1:0]  KEY_ONE_RESET = 32'h9dfa0f13;
  localparam logic [KEY_W-1:0]  KEY_TWO_RESET = 32'h62a4796d;
  localparam logic [BYTE_W-1:0] WHITEN_BYTE   = 8'hAB;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_ENCRYPT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DECRYPT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REBUILD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TWO = 2'd1;

  typedef logic [BYTE_W-1:0] byte_t;

  function automatic byte_t swap_nibbles(input byte_t v);
    swap_nibbles = {v[3:0], v[7:4]};
  endfunction

endpackage

// ----- rtl/keyed_byte_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// keyed_byte_stream_cipher
// Byte stream cipher over two 256-byte keystream memories rebuilt from keys.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Ports                                   Handshake
//  in_       input      in_action, in_data_in, in_last_in       in_valid / in_ready
//  out_      output     out_data_out, out_last_out, out_rebuilt out_valid / out_ready
//  cfg_      input      cfg_index, cfg_wdata                    cfg_we (no wait)
//
//  Encrypt, decrypt and unused actions are taken one per cycle unless the output
//  stalls, and may follow back to back; a result passes the memory read, then
//  the output register. A rebuild runs a multiply state and a write state per
//  table entry, since each new top byte needs two dependent multiplies. Input is
//  held off during the rebuild. Reset is synchronous and active low; bytes skip
//  the keystream until the first rebuild. A stalled output holds the pipeline.
//
module keyed_byte_stream_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kbsc_pkg::ACT_W-1:0]         in_action,
  input  logic [kbsc_pkg::BYTE_W-1:0]        in_data_in,
  input  logic                               in_last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [kbsc_pkg::BYTE_W-1:0]        out_data_out,
  output logic                               out_last_out,
  output logic                               out_rebuilt,
  input  logic                               cfg_we,
  input  logic [kbsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kbsc_pkg::KEY_W-1:0]         cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  localparam logic [kbsc_pkg::IDX_W-1:0] LAST_IDX = kbsc_pkg::IDX_W'(kbsc_pkg::HALF_DEPTH - 1);

  // Configuration
  logic [kbsc_pkg::KEY_W-1:0] key_one_r, key_two_r;

  // Keystream memories
  kbsc_pkg::byte_t low_mem  [kbsc_pkg::HALF_DEPTH];
  kbsc_pkg::byte_t high_mem [kbsc_pkg::HALF_DEPTH];
  kbsc_pkg::byte_t low_rd_r, high_rd_r;

  // Counters and table state
  logic [kbsc_pkg::CNT_W-1:0] enc_cnt_r, dec_cnt_r;
  logic                       built_r;

  // Rebuild sequencer
  logic [1:0]                 seq_state_r, seq_state_nxt;
  logic [kbsc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  kbsc_pkg::byte_t            top_lo_r, top_lo_nxt, top_hi_r, top_hi_nxt;
  kbsc_pkg::byte_t            prod_lo_r, prod_hi_r;
  logic                       rb_last_r;

  // Read stage
  logic            s1_valid_r, s1_xform_r, s1_rebuilt_r, s1_last_r, s1_built_r;
  kbsc_pkg::byte_t s1_byte_r;

  // Output register
  logic            out_valid_r, out_last_r, out_rebuilt_r;
  kbsc_pkg::byte_t out_data_r;

  logic out_free, s1_free, in_xfer, rd_en, seq_inject, mem_we, is_xform;
  logic [kbsc_pkg::CNT_W-1:0] rd_cnt;
  kbsc_pkg::byte_t k0_lo, k1_lo, k2_lo, k0_hi, k1_hi, k2_hi;

  assign out_free = !out_valid_r || out_ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign in_ready = (seq_state_r == ST_IDLE) && s1_free;
  assign in_xfer  = in_valid && in_ready;
  assign is_xform = (in_action == kbsc_pkg::ACT_ENCRYPT) ||
                    (in_action == kbsc_pkg::ACT_DECRYPT);
  assign rd_en    = in_xfer && is_xform;
  assign rd_cnt   = (in_action == kbsc_pkg::ACT_DECRYPT) ? dec_cnt_r : enc_cnt_r;

  assign k0_lo = key_one_r[7:0];
  assign k1_lo = key_one_r[15:8];
  assign k2_lo = key_one_r[23:16];
  assign k0_hi = key_two_r[7:0];
  assign k1_hi = key_two_r[15:8];
  assign k2_hi = key_two_r[23:16];

  // The rebuilt result enters the read stage with the last table write, once the read stage is free.
  assign mem_we     = (seq_state_r == ST_WRITE);
  assign seq_inject = mem_we && (idx_r == LAST_IDX) && s1_free;

  always_comb begin
    seq_state_nxt = seq_state_r;
    idx_nxt       = idx_r;
    top_lo_nxt    = top_lo_r;
    top_hi_nxt    = top_hi_r;
    unique case (seq_state_r)
      ST_IDLE: begin
        if (in_xfer && (in_action == kbsc_pkg::ACT_REBUILD)) begin
          seq_state_nxt = ST_MUL;
          idx_nxt       = '0;
          top_lo_nxt    = key_one_r[31:24];
          top_hi_nxt    = key_two_r[31:24];
        end
      end
      ST_MUL: begin
        seq_state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (idx_r == LAST_IDX) begin
          if (seq_inject) begin
            seq_state_nxt = ST_IDLE;
          end
        end else begin
          seq_state_nxt = ST_MUL;
          idx_nxt       = idx_r + 1'b1;
          top_lo_nxt    = kbsc_pkg::BYTE_W'((k1_lo + prod_lo_r) * top_lo_r + k0_lo);
          top_hi_nxt    = kbsc_pkg::BYTE_W'((k1_hi + prod_hi_r) * top_hi_r + k0_hi);
        end
      end
      default: begin
        seq_state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_one_r   <= kbsc_pkg::KEY_ONE_RESET;
      key_two_r   <= kbsc_pkg::KEY_TWO_RESET;
      enc_cnt_r   <= '0;
      dec_cnt_r   <= '0;
      built_r     <= 1'b0;
      seq_state_r <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kbsc_pkg::REG_KEY_ONE: key_one_r <= cfg_wdata;
          kbsc_pkg::REG_KEY_TWO: key_two_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (rd_en) begin
        if (in_action == kbsc_pkg::ACT_DECRYPT) begin
          dec_cnt_r <= dec_cnt_r + 1'b1;
        end else begin
          enc_cnt_r <= enc_cnt_r + 1'b1;
        end
      end
      if (seq_inject) begin
        built_r <= 1'b1;
      end
      seq_state_r <= seq_state_nxt;
      if (in_xfer && (in_action != kbsc_pkg::ACT_REBUILD)) begin
        s1_valid_r <= 1'b1;
      end else if (seq_inject) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    top_lo_r <= top_lo_nxt;
    top_hi_r <= top_hi_nxt;
    if (seq_state_r == ST_MUL) begin
      prod_lo_r <= kbsc_pkg::BYTE_W'(top_lo_r * k2_lo);
      prod_hi_r <= kbsc_pkg::BYTE_W'(top_hi_r * k2_hi);
    end
    // The end mark of a rebuild is held until its result leaves.
    if (in_xfer && (in_action == kbsc_pkg::ACT_REBUILD)) begin
      rb_last_r <= in_last_in;
    end
  end

  // Keystream memories: one write port from the sequencer, one read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      low_mem[idx_r]  <= top_lo_r;
      high_mem[idx_r] <= top_hi_r;
    end
    if (rd_en) begin
      low_rd_r  <= low_mem[rd_cnt[7:0]];
      high_rd_r <= high_mem[rd_cnt[15:8]];
    end
  end

  // Read stage payload
  always_ff @(posedge clk) begin
    if (in_xfer && (in_action != kbsc_pkg::ACT_REBUILD)) begin
      s1_xform_r   <= is_xform;
      s1_rebuilt_r <= 1'b0;
      s1_last_r    <= in_last_in;
      s1_built_r   <= built_r;
      s1_byte_r    <= kbsc_pkg::swap_nibbles(in_data_in ^ kbsc_pkg::WHITEN_BYTE);
    end else if (seq_inject) begin
      s1_xform_r   <= 1'b0;
      s1_rebuilt_r <= 1'b1;
      s1_last_r    <= rb_last_r;
      s1_built_r   <= 1'b1;
      s1_byte_r    <= '0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_last_r    <= s1_last_r;
      out_rebuilt_r <= s1_rebuilt_r;
      if (!s1_xform_r) begin
        out_data_r <= '0;
      end else if (s1_built_r) begin
        out_data_r <= s1_byte_r ^ low_rd_r ^ high_rd_r;
      end else begin
        out_data_r <= s1_byte_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last_out = out_last_r;
  assign out_rebuilt  = out_rebuilt_r;

  // A rebuild transfer starts the table sequencer on the next cycle.
  a_rebuild_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_action == kbsc_pkg::ACT_REBUILD) |=> seq_state_r == ST_MUL)
    else $error("rebuild transfer did not start the sequencer");

  // A completed rebuild never carries a data byte.
  a_rebuilt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rebuilt_r |-> out_data_r == '0)
    else $error("rebuilt result with nonzero data");

  // A blocked read stage keeps its item.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_byte_r))
    else $error("read stage lost an item under stall");

  // No transfer is taken while the tables are being rewritten.
  a_no_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_state_r != ST_IDLE |-> !in_ready)
    else $error("input taken during rebuild");

endmodule
